FILE: rtl/dur_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dur_pkg;

    // Width of the echo counters and stored widths.
    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Field widths.
    localparam int TIME_W = 16;
    localparam int DIST_W = 12;
    localparam int IDX_W  = 3;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] REG_TRIG_LOW  = 3'd0;
    localparam logic [IDX_W-1:0] REG_TRIG_HIGH = 3'd1;
    localparam logic [IDX_W-1:0] REG_OFFSET    = 3'd2;
    localparam logic [IDX_W-1:0] REG_TARGET    = 3'd3;
    localparam logic [IDX_W-1:0] REG_TOL       = 3'd4;

    // Register reset values.
    localparam logic [TIME_W-1:0] TRIG_LOW_RST  = 16'd48000;
    localparam logic [TIME_W-1:0] TRIG_HIGH_RST = 16'd2000;
    localparam logic [TIME_W-1:0] OFFSET_RST    = 16'd4000;
    localparam logic [DIST_W-1:0] TARGET_RST    = 12'd150;
    localparam logic [DIST_W-1:0] TOL_RST       = 12'd10;

    // Distance scale 340/10000 = 17/500, done as a multiply by
    // ceil(17 * 2^25 / 500) and a right shift by 25. This is exact for
    // every 16-bit width difference.
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 25;
    localparam logic [RECIP_W-1:0] RECIP_K = 21'd1140851;
    localparam int PROD_W = CNT_W + RECIP_W;

    // Steering command codes, shared by yaw and pitch.
    typedef enum logic [1:0] {
        STEER_NONE = 2'd0,
        STEER_POS  = 2'd1,
        STEER_NEG  = 2'd2
    } t_steer;

    // Contents of the first pipeline stage.
    typedef struct packed {
        logic             trig;
        logic [CNT_W-1:0] left_width;
        logic [CNT_W-1:0] right_width;
        t_steer           yaw;
        logic             equal;
        logic [CNT_W-1:0] diff;
    } t_stage;

endpackage

`default_nettype wire

FILE: rtl/dur_echo.sv
`timescale 1ns / 1ps
`default_nettype none

module dur_echo (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_step,
    input  wire logic                      i_level,
    input  wire logic                      i_clear,
    output logic [dur_pkg::CNT_W-1:0]      o_width_next
);
    import dur_pkg::*;

    logic             r_in_pulse;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_width;
    logic             n_in_pulse;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] n_width;

    // Pulse tracking with a saturating counter; a trigger rise clears the count.
    always_comb begin
        n_in_pulse = r_in_pulse;
        n_count    = r_count;
        n_width    = r_width;
        if (i_level) begin
            if (!r_in_pulse) begin
                n_in_pulse = 1'b1;
                n_count    = {{(CNT_W-1){1'b0}}, 1'b1};
            end else if (r_count != CNT_MAX) begin
                n_count = r_count + 1'b1;
            end
        end else if (r_in_pulse) begin
            n_in_pulse = 1'b0;
            n_width    = r_count;
        end
        if (i_clear) begin
            n_count = '0;
        end
    end

    assign o_width_next = n_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_pulse <= 1'b0;
            r_count    <= '0;
            r_width    <= '0;
        end else if (i_step) begin
            r_in_pulse <= n_in_pulse;
            r_count    <= n_count;
            r_width    <= n_width;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dur_trigger.sv
`timescale 1ns / 1ps
`default_nettype none

module dur_trigger (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic [dur_pkg::TIME_W-1:0] i_low_limit,
    input  wire logic [dur_pkg::TIME_W-1:0] i_high_limit,
    output logic                            o_level_next,
    output logic                            o_rise
);
    import dur_pkg::*;

    logic              r_high;
    logic [TIME_W-1:0] r_elapsed;
    logic [TIME_W-1:0] inc;
    logic [TIME_W-1:0] limit;
    logic              toggle;

    // Saturating phase timer; the level toggles when the phase limit is reached.
    assign inc    = (r_elapsed != {TIME_W{1'b1}}) ? r_elapsed + 1'b1 : r_elapsed;
    assign limit  = r_high ? i_high_limit : i_low_limit;
    assign toggle = (inc >= limit);

    assign o_level_next = toggle ? !r_high : r_high;
    assign o_rise       = toggle && !r_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high    <= 1'b0;
            r_elapsed <= '0;
        end else if (i_step) begin
            r_high    <= o_level_next;
            r_elapsed <= toggle ? '0 : inc;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dur_range.sv
`timescale 1ns / 1ps
`default_nettype none

module dur_range (
    input  wire logic                       i_equal,
    input  wire logic [dur_pkg::CNT_W-1:0]  i_diff,
    input  wire logic [dur_pkg::DIST_W-1:0] i_target,
    input  wire logic [dur_pkg::DIST_W-1:0] i_tol,
    output logic [dur_pkg::DIST_W-1:0]      o_distance,
    output dur_pkg::t_steer                 o_pitch
);
    import dur_pkg::*;

    logic [PROD_W-1:0]   prod;
    logic [DIST_W-1:0]   dist_cm;
    logic [DIST_W:0]     dist_plus_tol;
    logic [DIST_W:0]     upper;

    // Scale the width beyond the offset to centimeters.
    assign prod    = PROD_W'(i_diff) * PROD_W'(RECIP_K);
    assign dist_cm = prod[RECIP_SHIFT +: DIST_W];

    // Window test: below target - tol is too close, above target + tol too far.
    assign dist_plus_tol = {1'b0, dist_cm} + {1'b0, i_tol};
    assign upper         = {1'b0, i_target} + {1'b0, i_tol};

    always_comb begin
        o_distance = '0;
        o_pitch    = STEER_NONE;
        if (i_equal) begin
            o_distance = dist_cm;
            if (dist_plus_tol < {1'b0, i_target}) begin
                o_pitch = STEER_NEG;
            end else if ({1'b0, dist_cm} > upper) begin
                o_pitch = STEER_POS;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dual_ultrasonic_echo_ranger.sv
`timescale 1ns / 1ps
`default_nettype none

// Dual ultrasonic echo ranger.
// One input request per microsecond tick carries the sampled left and right
// echo levels. Each request yields one result request with the trigger level,
// the last completed echo widths on both sides, yaw and pitch commands and
// the distance in centimeters when the two widths match.
// From input acceptance to output valid a request passes the first
// register, which holds the updated widths, compare result and
// offset-corrected width, then the second, which holds the scaled
// distance and pitch. One request is taken every cycle while the output
// side accepts; the pitch path's single 16x21 multiply sets the cycle time.
// When the receiver stalls, the output register and the first stage hold
// and o_in_ready drops; nothing is lost or repeated.
// Synchronous reset clears the trigger timer, echo counters and pipeline
// valid flags and loads the configuration registers with their defaults.
// Configuration writes take effect in the cycle after i_cfg_we and are
// expected only while no request is in flight.

module dual_ultrasonic_echo_ranger (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [dur_pkg::IDX_W-1:0]  i_cfg_idx,
    input  wire logic [dur_pkg::TIME_W-1:0] i_cfg_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic                       i_left_echo,
    input  wire logic                       i_right_echo,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic                            o_trigger_level,
    output logic [15:0]                     o_left_width_us,
    output logic [15:0]                     o_right_width_us,
    output logic [1:0]                      o_yaw_command,
    output logic [1:0]                      o_pitch_command,
    output logic [11:0]                     o_distance_cm
);
    import dur_pkg::*;

    logic [TIME_W-1:0] r_trig_low;
    logic [TIME_W-1:0] r_trig_high;
    logic [TIME_W-1:0] r_offset;
    logic [DIST_W-1:0] r_target;
    logic [DIST_W-1:0] r_tol;

    logic              advance;
    logic              step;
    logic              trig_next;
    logic              trig_rise;
    logic              clear;
    logic [CNT_W-1:0]  left_next;
    logic [CNT_W-1:0]  right_next;
    t_stage            n_stage;
    t_stage            r_stage;
    logic              r_stage_valid;
    logic [DIST_W-1:0] dist_cm;
    t_steer            pitch;

    logic              r_out_valid;
    logic              r_trig;
    logic [CNT_W-1:0]  r_left;
    logic [CNT_W-1:0]  r_right;
    t_steer            r_yaw;
    t_steer            r_pitch;
    logic [DIST_W-1:0] r_dist;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_low  <= TRIG_LOW_RST;
            r_trig_high <= TRIG_HIGH_RST;
            r_offset    <= OFFSET_RST;
            r_target    <= TARGET_RST;
            r_tol       <= TOL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TRIG_LOW:  r_trig_low  <= i_cfg_data;
                REG_TRIG_HIGH: r_trig_high <= i_cfg_data;
                REG_OFFSET:    r_offset    <= i_cfg_data;
                REG_TARGET:    r_target    <= i_cfg_data[DIST_W-1:0];
                REG_TOL:       r_tol       <= i_cfg_data[DIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline moves when the output register is free or drained.
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = advance;
    assign step       = i_in_valid && advance;
    assign clear      = step && trig_rise;

    dur_trigger u_trigger (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_low_limit  (r_trig_low),
        .i_high_limit (r_trig_high),
        .o_level_next (trig_next),
        .o_rise       (trig_rise)
    );

    dur_echo u_left (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_level      (i_left_echo),
        .i_clear      (clear),
        .o_width_next (left_next)
    );

    dur_echo u_right (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_level      (i_right_echo),
        .i_clear      (clear),
        .o_width_next (right_next)
    );

    // First stage: compare the widths and remove the offset.
    always_comb begin
        n_stage.trig        = trig_next;
        n_stage.left_width  = left_next;
        n_stage.right_width = right_next;
        n_stage.equal       = 1'b0;
        if (left_next > right_next) begin
            n_stage.yaw = STEER_POS;
        end else if (left_next < right_next) begin
            n_stage.yaw = STEER_NEG;
        end else begin
            n_stage.yaw   = STEER_NONE;
            n_stage.equal = 1'b1;
        end
        n_stage.diff = (left_next > r_offset) ? left_next - r_offset : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_valid <= 1'b0;
        end else if (advance) begin
            r_stage_valid <= i_in_valid;
        end
        if (step) begin
            r_stage <= n_stage;
        end
    end

    dur_range u_range (
        .i_equal    (r_stage.equal),
        .i_diff     (r_stage.diff),
        .i_target   (r_target),
        .i_tol      (r_tol),
        .o_distance (dist_cm),
        .o_pitch    (pitch)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_stage_valid;
        end
        if (advance && r_stage_valid) begin
            r_trig  <= r_stage.trig;
            r_left  <= r_stage.left_width;
            r_right <= r_stage.right_width;
            r_yaw   <= r_stage.yaw;
            r_pitch <= pitch;
            r_dist  <= dist_cm;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_trigger_level  = r_trig;
    assign o_left_width_us  = r_left;
    assign o_right_width_us = r_right;
    assign o_yaw_command    = r_yaw;
    assign o_pitch_command  = r_pitch;
    assign o_distance_cm    = r_dist;

endmodule

`default_nettype wire

FILE: rtl/dur_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dur_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [15:0] o_left_width_us,
    input  wire logic [15:0] o_right_width_us,
    input  wire logic [1:0]  o_yaw_command,
    input  wire logic [1:0]  o_pitch_command,
    input  wire logic [11:0] o_distance_cm
);
    import dur_pkg::*;

    // A stalled result stays offered with the same widths.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_left_width_us)
            && $stable(o_right_width_us))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Yaw must agree with the reported widths.
    a_yaw_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_yaw_command == STEER_POS) == (o_left_width_us > o_right_width_us))
            && ((o_yaw_command == STEER_NEG) == (o_left_width_us < o_right_width_us)))
        else $error("yaw does not match widths");

    // Pitch and distance only come with equal widths.
    a_pitch_needs_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_yaw_command != STEER_NONE) |->
            (o_pitch_command == STEER_NONE) && (o_distance_cm == 12'd0))
        else $error("pitch or distance given with unequal widths");

endmodule

bind dual_ultrasonic_echo_ranger dur_checker u_dur_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_left_width_us  (o_left_width_us),
    .o_right_width_us (o_right_width_us),
    .o_yaw_command    (o_yaw_command),
    .o_pitch_command  (o_pitch_command),
    .o_distance_cm    (o_distance_cm)
);

`default_nettype wire
